/* hdl/suwl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suwl_pkg
// Shared constants and types for the smallest unique window length block.
// ----------------------------------------------------------------------------
package suwl_pkg;

   localparam int MAX_LEN = 1024;
   localparam int ADDR_W  = $clog2(MAX_LEN);
   localparam int CNT_W   = $clog2(MAX_LEN + 2);
   localparam int ELEM_W  = 31;
   localparam int LEN_W   = 11;
   localparam int HASH_W  = 30;
   localparam int KEY_W   = 2 * HASH_W;
   localparam int X_W     = 36;
   localparam int RED_W   = 3;

   localparam logic [HASH_W-1:0] MOD_A = 30'd1000000007;
   localparam logic [HASH_W-1:0] MOD_B = 30'd1000000009;
   localparam logic [X_W-1:0]    BASE_A = 36'd31;
   localparam logic [X_W-1:0]    BASE_B = 36'd37;
   localparam logic [RED_W-1:0]  RED_TOP = 3'd5;

   typedef struct packed {
      logic [CNT_W-1:0] count;
      logic             overflow;
   } job_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_TRIAL,
      S_WSTART,
      S_READ,
      S_MUL,
      S_RED,
      S_KI_RD,
      S_KI_GET,
      S_KJ_RD,
      S_KJ_CMP,
      S_DONE
   } state_type;

endpackage

/* hdl/suwl_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suwl_front
// Accepts element words, fills the element store and queues one job per array.
// ----------------------------------------------------------------------------
module suwl_front import suwl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ELEM_W-1:0] req_element,
   input  logic              req_last,
   output logic              job_push,
   output job_type           job_data,
   input  logic              job_full,
   input  logic              search_done,
   input  logic [ADDR_W-1:0] elem_rd_addr,
   output logic [ELEM_W-1:0] elem_rd_data
);

   logic [ELEM_W-1:0] elem_mem [MAX_LEN];
   logic [ELEM_W-1:0] elem_rd_data_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic              lock_ff, lock_in;
   logic              accept, room;
   logic [CNT_W-1:0]  count_next;
   logic              ovf_next;

   assign req_stall = lock_ff || job_full;
   assign accept    = req_valid && !req_stall;
   assign room      = count_ff < CNT_W'(MAX_LEN);
   assign count_next = room ? count_ff + CNT_W'(1) : count_ff;
   assign ovf_next   = ovf_ff || !room;

   always_comb begin
      count_in = count_ff;
      ovf_in   = ovf_ff;
      lock_in  = lock_ff;
      if (search_done) begin
         lock_in = 1'b0;
      end
      if (accept) begin
         if (req_last) begin
            count_in = '0;
            ovf_in   = 1'b0;
            lock_in  = 1'b1;
         end else begin
            count_in = count_next;
            ovf_in   = ovf_next;
         end
      end
   end

   assign job_push       = accept && req_last;
   assign job_data.count    = count_next;
   assign job_data.overflow = ovf_next;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         lock_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         lock_ff  <= lock_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         elem_mem[count_ff[ADDR_W-1:0]] <= req_element;
      end
   end

   always_ff @(posedge clock) begin
      elem_rd_data_ff <= elem_mem[elem_rd_addr];
   end

   assign elem_rd_data = elem_rd_data_ff;

endmodule

/* hdl/suwl_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suwl_fifo
// Two-entry job queue between the loader and the search engine.
// ----------------------------------------------------------------------------
module suwl_fifo import suwl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    avail,
   output job_type head
);

   job_type    slot_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic       rd_ff, rd_in;
   logic       wr_ptr;
   logic       do_push, do_pop;

   assign full    = fill_ff == 2'd2;
   assign avail   = fill_ff != 2'd0;
   assign do_push = push && !full;
   assign do_pop  = pop && avail;
   assign head    = slot_ff[rd_ff];
   assign wr_ptr  = rd_ff ^ fill_ff[0];

   always_comb begin
      fill_in = fill_ff;
      rd_in   = rd_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 2'd1;
      end
      if (do_pop) begin
         rd_in = !rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
         rd_ff   <= 1'b0;
      end else begin
         fill_ff <= fill_in;
         rd_ff   <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr] <= push_data;
      end
   end

endmodule

/* hdl/suwl_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// suwl_back
// Binary search over window lengths; hashes windows and checks uniqueness.
// ----------------------------------------------------------------------------
module suwl_back import suwl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              job_avail,
   input  job_type           job_head,
   output logic              job_pop,
   output logic              search_done,
   output logic [ADDR_W-1:0] elem_rd_addr,
   input  logic [ELEM_W-1:0] elem_rd_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LEN_W-1:0]  rsp_length,
   output logic              rsp_overflow
);

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  n_ff, lo_ff, hi_ff, best_ff, mid_ff;
   logic [CNT_W-1:0]  win_ff, k_ff, i_ff, j_ff;
   logic              ovf_ff;
   logic [HASH_W-1:0] ha_ff, hb_ff;
   logic [X_W-1:0]    xa_ff, xb_ff;
   logic [RED_W-1:0]  step_ff;
   logic [KEY_W-1:0]  ki_ff;
   logic [KEY_W-1:0]  key_mem [MAX_LEN];
   logic [KEY_W-1:0]  key_rd_data_ff;
   logic              rsp_valid_ff;
   logic [LEN_W-1:0]  rsp_length_ff;
   logic              rsp_ovf_ff;

   logic [CNT_W-1:0]  mid_calc, last_win;
   logic [X_W-1:0]    pa_sh, pb_sh, ra, rb;
   logic              key_we, out_free, lo_gt_hi, dup, last_k;
   logic [ADDR_W-1:0] key_rd_addr;

   assign mid_calc = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign last_win = n_ff - mid_ff;
   assign lo_gt_hi = lo_ff > hi_ff;
   assign pa_sh    = X_W'(MOD_A) << step_ff;
   assign pb_sh    = X_W'(MOD_B) << step_ff;
   assign ra       = (xa_ff >= pa_sh) ? xa_ff - pa_sh : xa_ff;
   assign rb       = (xb_ff >= pb_sh) ? xb_ff - pb_sh : xb_ff;
   assign last_k   = k_ff == mid_ff - CNT_W'(1);
   assign dup      = (j_ff != i_ff) && (key_rd_data_ff == ki_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (job_avail) state_in = S_TRIAL;
         S_TRIAL:  state_in = lo_gt_hi ? S_DONE : S_WSTART;
         S_WSTART: state_in = S_READ;
         S_READ:   state_in = S_MUL;
         S_MUL:    state_in = S_RED;
         S_RED: begin
            if (step_ff == '0) begin
               if (!last_k) state_in = S_READ;
               else if (win_ff == last_win) state_in = S_KI_RD;
               else state_in = S_WSTART;
            end
         end
         S_KI_RD:  state_in = S_KI_GET;
         S_KI_GET: state_in = S_KJ_RD;
         S_KJ_RD:  state_in = S_KJ_CMP;
         S_KJ_CMP: begin
            if (dup) state_in = (i_ff == last_win) ? S_TRIAL : S_KI_RD;
            else if (j_ff == last_win) state_in = S_TRIAL;
            else state_in = S_KJ_RD;
         end
         S_DONE:   if (out_free) state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      job_pop      = 1'b0;
      search_done  = 1'b0;
      key_we       = 1'b0;
      elem_rd_addr = ADDR_W'(win_ff + k_ff);
      key_rd_addr  = i_ff[ADDR_W-1:0];
      case (state_ff)
         S_IDLE:   job_pop = job_avail;
         S_TRIAL:  search_done = lo_gt_hi;
         S_RED:    key_we = (step_ff == '0) && last_k;
         S_KJ_RD:  key_rd_addr = j_ff[ADDR_W-1:0];
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            n_ff    <= job_head.count;
            ovf_ff  <= job_head.overflow;
            lo_ff   <= CNT_W'(1);
            hi_ff   <= job_head.count;
            best_ff <= job_head.count;
         end
         S_TRIAL: begin
            mid_ff <= mid_calc;
            win_ff <= '0;
         end
         S_WSTART: begin
            ha_ff <= '0;
            hb_ff <= '0;
            k_ff  <= '0;
         end
         S_MUL: begin
            xa_ff   <= X_W'(ha_ff) * BASE_A + X_W'(elem_rd_data);
            xb_ff   <= X_W'(hb_ff) * BASE_B + X_W'(elem_rd_data);
            step_ff <= RED_TOP;
         end
         S_RED: begin
            xa_ff   <= ra;
            xb_ff   <= rb;
            step_ff <= step_ff - RED_W'(1);
            if (step_ff == '0) begin
               ha_ff <= ra[HASH_W-1:0];
               hb_ff <= rb[HASH_W-1:0];
               k_ff  <= k_ff + CNT_W'(1);
               if (last_k) begin
                  win_ff <= win_ff + CNT_W'(1);
                  i_ff   <= '0;
               end
            end
         end
         S_KI_GET: begin
            ki_ff <= key_rd_data_ff;
            j_ff  <= '0;
         end
         S_KJ_CMP: begin
            j_ff <= j_ff + CNT_W'(1);
            if (dup) begin
               i_ff <= i_ff + CNT_W'(1);
               if (i_ff == last_win) lo_ff <= mid_ff + CNT_W'(1);
            end else if (j_ff == last_win) begin
               // window i has no twin
               best_ff <= mid_ff;
               hi_ff   <= mid_ff - CNT_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[win_ff[ADDR_W-1:0]] <= {ra[HASH_W-1:0], rb[HASH_W-1:0]};
      end
      key_rd_data_ff <= key_mem[key_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_DONE && out_free) begin
         rsp_length_ff <= LEN_W'(best_ff);
         rsp_ovf_ff    <= ovf_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_length   = rsp_length_ff;
   assign rsp_overflow = rsp_ovf_ff;

endmodule

/* hdl/smallest_unique_window_length.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smallest_unique_window_length
// Finds the shortest window length with a uniquely occurring hash pair.
// ----------------------------------------------------------------------------
// Elements load one word per cycle while req_stall is low, until a word with
// last set. The search then runs with req_stall high: for each trial length L
// over n elements it hashes all n-L+1 windows directly, each element taking a
// read, a multiply-add and six restoring reduction steps against the modulus,
// then compares window keys pairwise, each compare taking a read state and a
// compare state through the single read port of the key memory. About
// log2(n)+1 trials run per array. Loading of the next array resumes as soon as
// the search ends, even while the result word still waits on rsp_stall.
module smallest_unique_window_length import suwl_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [ELEM_W-1:0] req_element,
   input  logic              req_last,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [LEN_W-1:0]  rsp_length,
   output logic              rsp_overflow
);

   logic              job_push, job_full, job_pop, job_avail, search_done;
   job_type           job_in, job_head;
   logic [ADDR_W-1:0] elem_rd_addr;
   logic [ELEM_W-1:0] elem_rd_data;

   suwl_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_element  (req_element),
      .req_last     (req_last),
      .job_push     (job_push),
      .job_data     (job_in),
      .job_full     (job_full),
      .search_done  (search_done),
      .elem_rd_addr (elem_rd_addr),
      .elem_rd_data (elem_rd_data)
   );

   suwl_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_in),
      .full      (job_full),
      .pop       (job_pop),
      .avail     (job_avail),
      .head      (job_head)
   );

   suwl_back u_back (
      .clock        (clock),
      .reset        (reset),
      .job_avail    (job_avail),
      .job_head     (job_head),
      .job_pop      (job_pop),
      .search_done  (search_done),
      .elem_rd_addr (elem_rd_addr),
      .elem_rd_data (elem_rd_data),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_length   (rsp_length),
      .rsp_overflow (rsp_overflow)
   );

endmodule
